// ===== design/assert_macros.svh =====
// Assertion macros used by the checker of the status LED controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, ignored while reset is held.
`define SLC_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Concurrent assertion on the rising clock edge that also covers reset.
`define SLC_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/slc_pkg.sv =====
// Package with types, codes and constants of the status LED controller.
`timescale 1ns / 1ps

package slc_pkg;

    // Input request payload.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ms;
    } slc_in_t;

    // Result payload.
    typedef struct packed {
        logic [7:0] life_level;
        logic       act_led;
        logic       power_led;
    } slc_out_t;

    // Opcodes.
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ACTIVITY = 3'd1;
    localparam logic [2:0] OP_SAFETY   = 3'd2;
    localparam logic [2:0] OP_ERROR    = 3'd3;
    localparam logic [2:0] OP_SHUTDOWN = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LIFE_PERIOD     = 3'd0;
    localparam logic [2:0] CFG_ACT_PULSE       = 3'd1;
    localparam logic [2:0] CFG_SAFETY_DURATION = 3'd2;
    localparam logic [2:0] CFG_SAFETY_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_ERROR_DURATION  = 3'd4;
    localparam logic [2:0] CFG_ERROR_INTERVAL  = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_LIFE_PERIOD     = 16'd2000;
    localparam logic [15:0] RST_ACT_PULSE       = 16'd50;
    localparam logic [15:0] RST_SAFETY_DURATION = 16'd3000;
    localparam logic [15:0] RST_SAFETY_INTERVAL = 16'd250;
    localparam logic [15:0] RST_ERROR_DURATION  = 16'd5000;
    localparam logic [15:0] RST_ERROR_INTERVAL  = 16'd100;

    // Triangle wave scaling: full swing and fold point.
    localparam logic [8:0]  LIFE_SWING = 9'd510;
    localparam logic [8:0]  LIFE_PEAK  = 9'd255;

    // Divider operand selection.
    localparam logic [1:0] DIV_PHASE = 2'd0;
    localparam logic [1:0] DIV_SCALE = 2'd1;
    localparam logic [1:0] DIV_BLINK = 2'd2;

    // Number of two-bit divider steps for each division.
    localparam logic [4:0] PAIRS_PHASE = 5'd16;
    localparam logic [4:0] PAIRS_SCALE = 5'd13;
    localparam logic [4:0] PAIRS_BLINK = 5'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mul_en;
        logic       life_cap;
        logic       blink_cap;
        logic       commit;
        logic       out_load;
    } slc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] opcode;
        logic       period_zero;
        logic       blink_need;
        logic       div_done;
        logic       out_free;
    } slc_stat_t;

endpackage

// ===== design/slc_divider.sv =====
// Shared restoring divider, two quotient bits per clock cycle.
`timescale 1ns / 1ps

module slc_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    input  logic [4:0]  pairs,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);
    import slc_pkg::*;

    logic [31:0] work_reg;
    logic [15:0] rem_reg;
    logic [15:0] div_reg;
    logic [4:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [16:0] step1;
    logic [16:0] step2;
    logic [31:0] work_next;

    // One restoring step: returns the quotient bit on top of the new remainder.
    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic        in_bit,
                                             input logic [15:0] d);
        logic [16:0] t;
        logic [16:0] diff;
        t    = {rem, in_bit};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            div_step = {1'b1, diff[15:0]};
        end else begin
            div_step = {1'b0, t[15:0]};
        end
    endfunction

    always_comb begin
        step1     = div_step(rem_reg, work_reg[31], div_reg);
        step2     = div_step(step1[15:0], work_reg[30], div_reg);
        work_next = {work_reg[29:0], step1[16], step2[16]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= pairs;
            end else if (busy_reg) begin
                count_reg <= count_reg - 5'd1;
                if (count_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= step2[15:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/slc_datapath.sv =====
// Datapath: configuration, LED timer state, divider operands and result register.
`timescale 1ns / 1ps

module slc_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  slc_pkg::slc_in_t  s_data,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_index,
    input  logic [15:0]       cfg_wr_data,
    input  slc_pkg::slc_cmd_t cmd,
    output slc_pkg::slc_stat_t stat,
    output logic              m_valid,
    input  logic              m_ready,
    output slc_pkg::slc_out_t m_data
);
    import slc_pkg::*;

    // Configuration registers.
    logic [15:0] life_period_reg;
    logic [15:0] act_pulse_reg;
    logic [15:0] safety_duration_reg;
    logic [15:0] safety_interval_reg;
    logic [15:0] error_duration_reg;
    logic [15:0] error_interval_reg;

    // Current request.
    logic [2:0]  opcode_reg;
    logic [31:0] now_reg;

    // LED timer state.
    logic        act_active_reg;
    logic [31:0] act_begin_reg;
    logic        blink_active_reg;
    logic [31:0] blink_begin_reg;
    logic [15:0] blink_length_reg;
    logic [15:0] blink_half_reg;
    logic [7:0]  life_pin_reg;
    logic        act_pin_reg;
    logic        power_pin_reg;

    // Intermediate results.
    logic [24:0] prod_reg;
    logic [8:0]  life_v_reg;
    logic        parity_reg;

    // Result register.
    logic        out_valid_reg;
    slc_out_t    out_data_reg;

    logic [31:0] blink_elapsed;
    logic [31:0] act_elapsed;
    logic        blink_need;
    logic [7:0]  life_fold;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic [4:0]  div_pairs;
    logic        div_done;
    logic [31:0] div_quotient;
    logic [15:0] div_remainder;
    logic [15:0] start_length;
    logic [15:0] start_half;
    logic [8:0]  fold_diff;

    assign blink_elapsed = now_reg - blink_begin_reg;
    assign act_elapsed   = now_reg - act_begin_reg;
    assign blink_need    = blink_active_reg && (blink_elapsed <= {16'd0, blink_length_reg});
    assign fold_diff     = LIFE_SWING - life_v_reg;
    assign life_fold     = (life_v_reg > LIFE_PEAK) ? fold_diff[7:0] : life_v_reg[7:0];

    always_comb begin
        case (cmd.div_sel)
            DIV_SCALE: begin
                div_dividend = {1'b0, prod_reg, 6'd0};
                div_divisor  = life_period_reg;
                div_pairs    = PAIRS_SCALE;
            end
            DIV_BLINK: begin
                div_dividend = {blink_elapsed[15:0], 16'd0};
                div_divisor  = blink_half_reg;
                div_pairs    = PAIRS_BLINK;
            end
            default: begin
                div_dividend = now_reg;
                div_divisor  = life_period_reg;
                div_pairs    = PAIRS_PHASE;
            end
        endcase
    end

    always_comb begin
        if (opcode_reg == OP_ERROR) begin
            start_length = error_duration_reg;
            start_half   = error_interval_reg;
        end else begin
            start_length = safety_duration_reg;
            start_half   = safety_interval_reg;
        end
        if (start_half == 16'd0) begin
            start_half = 16'd1;
        end
    end

    slc_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .pairs     (div_pairs),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            life_period_reg     <= RST_LIFE_PERIOD;
            act_pulse_reg       <= RST_ACT_PULSE;
            safety_duration_reg <= RST_SAFETY_DURATION;
            safety_interval_reg <= RST_SAFETY_INTERVAL;
            error_duration_reg  <= RST_ERROR_DURATION;
            error_interval_reg  <= RST_ERROR_INTERVAL;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_LIFE_PERIOD:     life_period_reg     <= cfg_wr_data;
                CFG_ACT_PULSE:       act_pulse_reg       <= cfg_wr_data;
                CFG_SAFETY_DURATION: safety_duration_reg <= cfg_wr_data;
                CFG_SAFETY_INTERVAL: safety_interval_reg <= cfg_wr_data;
                CFG_ERROR_DURATION:  error_duration_reg  <= cfg_wr_data;
                CFG_ERROR_INTERVAL:  error_interval_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            opcode_reg <= s_data.opcode;
            now_reg    <= s_data.now_ms;
        end
        if (cmd.mul_en) begin
            prod_reg <= {9'd0, div_remainder} * 25'd510;
        end
        if (cmd.life_cap) begin
            life_v_reg <= div_quotient[8:0];
        end
        if (cmd.blink_cap) begin
            parity_reg <= div_quotient[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_active_reg   <= 1'b0;
            act_begin_reg    <= '0;
            blink_active_reg <= 1'b0;
            blink_begin_reg  <= '0;
            blink_length_reg <= '0;
            blink_half_reg   <= 16'd1;
            life_pin_reg     <= '0;
            act_pin_reg      <= 1'b0;
            power_pin_reg    <= 1'b1;
        end else if (cmd.commit) begin
            case (opcode_reg)
                OP_TICK: begin
                    if (life_period_reg != 16'd0) begin
                        life_pin_reg <= life_fold;
                    end
                    if (act_active_reg) begin
                        if (act_elapsed > {16'd0, act_pulse_reg}) begin
                            act_pin_reg    <= 1'b0;
                            act_active_reg <= 1'b0;
                        end else begin
                            act_pin_reg <= 1'b1;
                        end
                    end
                    if (blink_active_reg) begin
                        if (!blink_need) begin
                            power_pin_reg    <= 1'b1;
                            blink_active_reg <= 1'b0;
                        end else begin
                            power_pin_reg <= ~parity_reg;
                        end
                    end
                end
                OP_ACTIVITY: begin
                    act_active_reg <= 1'b1;
                    act_begin_reg  <= now_reg;
                end
                OP_SAFETY, OP_ERROR: begin
                    blink_active_reg <= 1'b1;
                    blink_begin_reg  <= now_reg;
                    blink_length_reg <= start_length;
                    blink_half_reg   <= start_half;
                end
                OP_SHUTDOWN: begin
                    life_pin_reg  <= '0;
                    act_pin_reg   <= 1'b0;
                    power_pin_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg.life_level <= life_pin_reg;
            out_data_reg.act_led    <= act_pin_reg;
            out_data_reg.power_led  <= power_pin_reg;
        end
    end

    assign stat.opcode      = opcode_reg;
    assign stat.period_zero = (life_period_reg == 16'd0);
    assign stat.blink_need  = blink_need;
    assign stat.div_done    = div_done;
    assign stat.out_free    = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/slc_ctrl.sv =====
// Controller state machine that sequences the divisions and the state update.
`timescale 1ns / 1ps

module slc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  slc_pkg::slc_stat_t stat,
    output slc_pkg::slc_cmd_t  cmd
);
    import slc_pkg::*;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_DISPATCH   = 3'd1;
    localparam logic [2:0] ST_WAIT_PHASE = 3'd2;
    localparam logic [2:0] ST_SCALE      = 3'd3;
    localparam logic [2:0] ST_WAIT_SCALE = 3'd4;
    localparam logic [2:0] ST_WAIT_BLINK = 3'd5;
    localparam logic [2:0] ST_COMMIT     = 3'd6;
    localparam logic [2:0] ST_OUTPUT     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_PHASE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.opcode != OP_TICK) begin
                    state_next = ST_COMMIT;
                end else if (!stat.period_zero) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_PHASE;
                    state_next    = ST_WAIT_PHASE;
                end else if (stat.blink_need) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_BLINK;
                    state_next    = ST_WAIT_BLINK;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_WAIT_PHASE: begin
                if (stat.div_done) begin
                    cmd.mul_en = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SCALE;
                state_next    = ST_WAIT_SCALE;
            end
            ST_WAIT_SCALE: begin
                if (stat.div_done) begin
                    cmd.life_cap = 1'b1;
                    if (stat.blink_need) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_BLINK;
                        state_next    = ST_WAIT_BLINK;
                    end else begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_WAIT_BLINK: begin
                cmd.div_sel = DIV_BLINK;
                if (stat.div_done) begin
                    cmd.blink_cap = 1'b1;
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== design/status_led_controller_top.sv =====
// Top level of the status LED controller.
`timescale 1ns / 1ps

// Status LED controller. Each request carries an opcode and the current
// millisecond time, and each request produces exactly one result holding the
// life LED duty level and the activity and power LED pin levels after the
// request has been applied. Requests are handled one at a time. An activity,
// safety, error or shutdown request, a request with an unused opcode, and a
// tick with the breathing period set to zero and no blink in progress, run no
// division. A tick with a nonzero breathing period runs up to three divisions
// in sequence on one shared divider that retires two quotient bits per cycle:
// the phase (16 steps), the scaled duty level (13 steps) and, while a blink is
// in progress, the blink half period count (8 steps). A tick with a zero
// breathing period while a blink is in progress runs only the blink division.
// A new request is taken as soon as the previous one has been handed to the
// output register, even while that result still waits for m_ready; if the
// earlier result is still waiting when the next one is ready, the next one is
// held until m_ready takes the earlier one. Configuration registers are
// written through the cfg_wr_* port, one per cycle, and must only be written
// while the block is idle; writes to indexes beyond the last register are
// ignored.
module status_led_controller_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  slc_pkg::slc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output slc_pkg::slc_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_index,
    input  logic [15:0]       cfg_wr_data
);
    import slc_pkg::*;

    // Commands flow from the controller into the datapath, and status flows
    // back; there is no other connection between the two.
    slc_cmd_t  cmd;
    slc_stat_t stat;

    // The controller decides which division runs next and when the LED state
    // is committed and the result is loaded into the output register.
    slc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the timer state, the shared
    // divider and the output register.
    slc_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data       (s_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// ===== design/slc_checker.sv =====
// Port level checker for the status LED controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input slc_pkg::slc_out_t m_data,
    input logic              cfg_wr_en
);
    import slc_pkg::*;

    logic in_take;
    logic out_stall;

    assign in_take   = s_valid && s_ready;
    assign out_stall = m_valid && !m_ready;

    // A stalled result keeps its value.
    `SLC_ASSERT_RUN(a_out_hold, out_stall |=> (m_valid && $stable(m_data)), "stalled result changed")

    // Reset empties the output register.
    `SLC_ASSERT_ALL(a_out_reset, !aresetn |=> !m_valid, "result valid after reset")

    // Requests are processed one at a time.
    `SLC_ASSERT_RUN(a_busy_after_accept, in_take |=> !s_ready, "request taken while busy")

    // A result never appears in the cycle right after a request is taken.
    `SLC_ASSERT_RUN(a_no_instant_result, in_take |=> !$rose(m_valid), "result too early")

    // Configuration is only written while the block is idle.
    `SLC_ASSERT_RUN(a_cfg_idle, cfg_wr_en |-> (s_ready && !m_valid), "configuration written while busy")

endmodule

bind status_led_controller_top slc_checker u_slc_checker (.*);
